FILE: src/scc_pkg.sv
// shared types and constants for the chi-square histogram cost unit
package scc_pkg;

    typedef struct packed {
        logic last;
        logic dummy;
        logic empty;
    } bin_flags_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SQUARE,
        BK_DIVIDE,
        BK_ACCUM
    } back_state_t;

    localparam int unsigned QUEUE_DEPTH = 4;

endpackage

FILE: src/scc_front.sv
// input side: takes bin transfers, forms |t-s| and t+s, flags empty bins
module scc_front #(
    parameter int unsigned COUNT_BITS = 12,
    parameter int unsigned IN_W       = 24
) (
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_W-1:0]         s_tdata,
    input  logic                    s_tlast,
    input  logic                    s_tuser,
    input  logic                    q_full,
    output logic                    q_push,
    output logic [COUNT_BITS-1:0]   bin_diff,
    output logic [COUNT_BITS:0]     bin_den,
    output scc_pkg::bin_flags_t     bin_flags
);
    import scc_pkg::*;

    logic [COUNT_BITS-1:0] t_cnt;
    logic [COUNT_BITS-1:0] s_cnt;

    assign t_cnt = s_tdata[COUNT_BITS-1:0];
    assign s_cnt = s_tdata[2*COUNT_BITS-1:COUNT_BITS];

    assign s_tready = ~q_full;
    assign q_push   = s_tvalid & ~q_full;

    always_comb begin
        bin_diff        = (t_cnt >= s_cnt) ? (t_cnt - s_cnt) : (s_cnt - t_cnt);
        bin_den         = {1'b0, t_cnt} + {1'b0, s_cnt};
        bin_flags.last  = s_tlast;
        bin_flags.dummy = s_tuser;
        bin_flags.empty = (bin_den == '0);
    end

endmodule

FILE: src/scc_fifo.sv
// short queue between the front and back parts
module scc_fifo #(
    parameter int unsigned DATA_W = 28,
    parameter int unsigned DEPTH  = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [AW:0]       count_reg, count_next;

    assign full     = (count_reg == (AW+1)'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop && !empty) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push && !full, pop && !empty})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: src/scc_back.sv
// back part: square, bit-serial divide, saturating accumulate, result register
module scc_back #(
    parameter int unsigned COUNT_BITS = 12,
    parameter int unsigned FRAC_BITS  = 8,
    parameter int unsigned COST_BITS  = 28
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_empty,
    output logic                    q_pop,
    input  logic [COUNT_BITS-1:0]   bin_diff,
    input  logic [COUNT_BITS:0]     bin_den,
    input  scc_pkg::bin_flags_t     bin_flags,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [COST_BITS-1:0]    out_cost,
    output logic                    out_sat
);
    import scc_pkg::*;

    localparam int unsigned DEN_W  = COUNT_BITS + 1;
    localparam int unsigned SQ_W   = 2 * COUNT_BITS;
    localparam int unsigned NUM_W  = SQ_W + FRAC_BITS;
    localparam int unsigned QW     = COUNT_BITS + FRAC_BITS;
    localparam int unsigned CNT_W  = $clog2(NUM_W);
    localparam int unsigned SUM_W  = ((QW > COST_BITS) ? QW : COST_BITS) + 1;
    localparam logic [COST_BITS-1:0] COST_MAX = {COST_BITS{1'b1}};

    back_state_t           state_reg, state_next;
    logic [COUNT_BITS-1:0] diff_reg, diff_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    bin_flags_t            flags_reg, flags_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    logic [DEN_W-1:0]      rem_reg, rem_next;
    logic [QW-1:0]         quot_reg, quot_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [COST_BITS-1:0]  sum_reg, sum_next;
    logic                  clip_reg, clip_next;
    logic                  out_valid_reg, out_valid_next;
    logic [COST_BITS-1:0]  out_cost_reg, out_cost_next;
    logic                  out_sat_reg, out_sat_next;

    logic [SQ_W-1:0]       square;
    logic [DEN_W:0]        trial;
    logic                  qbit;
    logic [SUM_W-1:0]      sum_ext;
    logic                  overflow;
    logic [COST_BITS-1:0]  sum_add;
    logic                  clip_add;
    logic                  out_free;

    assign out_valid = out_valid_reg;
    assign out_cost  = out_cost_reg;
    assign out_sat   = out_sat_reg;

    always_comb begin
        square   = SQ_W'(diff_reg) * SQ_W'(diff_reg);
        trial    = {rem_reg, num_reg[NUM_W-1]};
        qbit     = (trial >= {1'b0, den_reg});
        sum_ext  = SUM_W'(sum_reg) + SUM_W'(quot_reg);
        overflow = (sum_ext > SUM_W'(COST_MAX));
        sum_add  = overflow ? COST_MAX : sum_ext[COST_BITS-1:0];
        clip_add = clip_reg | overflow;
        out_free = !out_valid_reg || out_ready;
    end

    always_comb begin
        state_next     = state_reg;
        diff_next      = diff_reg;
        den_next       = den_reg;
        flags_next     = flags_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        clip_next      = clip_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_cost_next  = out_cost_reg;
        out_sat_next   = out_sat_reg;
        q_pop          = 1'b0;
        case (state_reg)
            BK_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    diff_next  = bin_diff;
                    den_next   = bin_den;
                    flags_next = bin_flags;
                    quot_next  = '0;
                    state_next = bin_flags.empty ? BK_ACCUM : BK_SQUARE;
                end
            end
            BK_SQUARE: begin
                num_next   = NUM_W'(square) << FRAC_BITS;
                rem_next   = '0;
                quot_next  = '0;
                cnt_next   = '0;
                state_next = BK_DIVIDE;
            end
            BK_DIVIDE: begin
                rem_next  = qbit ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
                quot_next = {quot_reg[QW-2:0], qbit};
                num_next  = {num_reg[NUM_W-2:0], 1'b0};
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    state_next = BK_ACCUM;
                end
            end
            BK_ACCUM: begin
                if (!flags_reg.last) begin
                    sum_next   = sum_add;
                    clip_next  = clip_add;
                    state_next = BK_IDLE;
                end else if (out_free) begin
                    out_valid_next = 1'b1;
                    out_cost_next  = flags_reg.dummy ? '0 : sum_add;
                    out_sat_next   = flags_reg.dummy ? 1'b0 : clip_add;
                    sum_next       = '0;
                    clip_next      = 1'b0;
                    state_next     = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BK_IDLE;
            sum_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            clip_reg      <= clip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        diff_reg     <= diff_next;
        den_reg      <= den_next;
        flags_reg    <= flags_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        cnt_reg      <= cnt_next;
        out_cost_reg <= out_cost_next;
        out_sat_reg  <= out_sat_next;
    end

endmodule

FILE: src/shape_context_chi_square_cost_unit.sv
// top level of the shape-context chi-square matching cost unit
// Each input transfer is one histogram bin pair; the bin adds
// floor((t-s)^2 * 2^FRAC_BITS / (t+s)) to a saturating running sum, and the transfer
// with tlast high emits the pair cost (zero when tuser marks a dummy pair) and clears
// the sum. Bins are taken into a 4-entry queue at up to one per cycle while it is not
// full, then handled one at a time: a non-empty bin is squared, then divided by the
// one-quotient-bit-per-cycle restoring divider, then added to the sum; a bin with both
// counts zero skips the square and divide. The result waits in an output register, so
// the next pair keeps accumulating while it is held off.
module shape_context_chi_square_cost_unit #(
    parameter int unsigned COUNT_BITS = 12,
    parameter int unsigned FRAC_BITS  = 8,
    parameter int unsigned COST_BITS  = 28
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // template_count, search_count
    input  logic [((2*COUNT_BITS+7)/8)*8-1:0]      s_tdata,
    input  logic                                   s_tlast,
    // dummy_pair
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // pair_cost
    output logic [((COST_BITS+7)/8)*8-1:0]         m_tdata,
    // cost_saturated
    output logic                                   m_tuser
);
    import scc_pkg::*;

    localparam int unsigned IN_W  = ((2*COUNT_BITS+7)/8)*8;
    localparam int unsigned OUT_W = ((COST_BITS+7)/8)*8;
    localparam int unsigned FL_W  = $bits(bin_flags_t);
    localparam int unsigned ENT_W = COUNT_BITS + (COUNT_BITS + 1) + FL_W;

    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    logic [COUNT_BITS-1:0] f_diff;
    logic [COUNT_BITS:0]   f_den;
    bin_flags_t            f_flags;
    logic [ENT_W-1:0]      q_wdata;
    logic [ENT_W-1:0]      q_rdata;
    logic [COUNT_BITS-1:0] b_diff;
    logic [COUNT_BITS:0]   b_den;
    bin_flags_t            b_flags;
    logic [COST_BITS-1:0]  out_cost;

    assign q_wdata = {f_flags, f_den, f_diff};
    assign b_diff  = q_rdata[COUNT_BITS-1:0];
    assign b_den   = q_rdata[2*COUNT_BITS:COUNT_BITS];
    assign b_flags = bin_flags_t'(q_rdata[ENT_W-1:2*COUNT_BITS+1]);
    assign m_tdata = OUT_W'(out_cost);

    scc_front #(
        .COUNT_BITS (COUNT_BITS),
        .IN_W       (IN_W)
    ) u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .q_full    (q_full),
        .q_push    (q_push),
        .bin_diff  (f_diff),
        .bin_den   (f_den),
        .bin_flags (f_flags)
    );

    scc_fifo #(
        .DATA_W (ENT_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .full      (q_full),
        .empty     (q_empty)
    );

    scc_back #(
        .COUNT_BITS (COUNT_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .COST_BITS  (COST_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .bin_diff  (b_diff),
        .bin_den   (b_den),
        .bin_flags (b_flags),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_cost  (out_cost),
        .out_sat   (m_tuser)
    );

endmodule

FILE: src/scc_checker.sv
// port-level checks for the chi-square cost unit, bound to the top level
module scc_checker #(
    parameter int unsigned COUNT_BITS = 12,
    parameter int unsigned COST_BITS  = 28
) (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tvalid,
    input logic                               s_tready,
    input logic [((2*COUNT_BITS+7)/8)*8-1:0]  s_tdata,
    input logic                               s_tlast,
    input logic                               s_tuser,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [((COST_BITS+7)/8)*8-1:0]     m_tdata,
    input logic                               m_tuser
);

    // no result right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result transfer holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a clipped cost sits at full scale
    a_sat_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[COST_BITS-1:0] == {COST_BITS{1'b1}})
        else $error("saturated cost below full scale");

endmodule

bind shape_context_chi_square_cost_unit scc_checker #(
    .COUNT_BITS (COUNT_BITS),
    .COST_BITS  (COST_BITS)
) u_scc_checker (.*);
